// File: hdl/glyph_row_pixel_frame_encoder_top_macros.svh
// Assertion macros for the glyph row pixel frame encoder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef GLYPH_ROW_PIXEL_FRAME_ENCODER_TOP_MACROS_SVH
`define GLYPH_ROW_PIXEL_FRAME_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define GRPFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled during reset.
`define GRPFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`else

`define GRPFE_ASSERT_NOW(label, clk, rst, ante, cons)
`define GRPFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/grpfe_pkg.sv
// Shared types, codes and helper functions for the glyph row pixel frame encoder.
// No dependencies.
package grpfe_pkg;

  localparam int OpcodeW = 3;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 12;
  localparam int ColorW = 12;
  localparam int FrameW = 9;
  localparam int MaxPairs = 4;

  localparam logic [OpcodeW-1:0] OP_GLYPH = 3'd0;
  localparam logic [OpcodeW-1:0] OP_FILL  = 3'd1;
  localparam logic [OpcodeW-1:0] OP_CMD   = 3'd2;
  localparam logic [OpcodeW-1:0] OP_COORD = 3'd3;
  localparam logic [OpcodeW-1:0] OP_DATA  = 3'd4;

  localparam logic [CfgIndexW-1:0] REG_FG_COLOR     = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_BG_COLOR     = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_INVERT_GLYPH = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_GLYPH_WIDTH  = 3'd3;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  // One item waiting to be expanded into frames.
  typedef struct packed {
    logic       single;   // one frame of byte_val and flag
    logic [7:0] byte_val; // glyph bits (inverted already) or frame byte
    logic       flag;     // data flag for a single frame
    logic [2:0] pairs;    // pixel pairs of a glyph or fill item, 1..4
  } item_t;

  function automatic logic [3:0] nib_rev(input logic [3:0] n);
    nib_rev = {n[0], n[1], n[2], n[3]};
  endfunction

  function automatic logic [7:0] byte_rev(input logic [7:0] b);
    byte_rev = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
  endfunction

endpackage

// File: hdl/glyph_row_pixel_frame_encoder_top.sv
// Glyph row pixel frame encoder: turns display items into 9-bit serial LCD frames.
// Depends on grpfe_pkg and glyph_row_pixel_frame_encoder_top_macros.svh.
//
// Input channel (in_valid/in_ready, opcode, value): one item per handshake.
// A glyph row gives three frames per pixel pair (min(glyph_width/2, 4) pairs),
// a fill item three frames, a command, coordinate or data item one frame,
// unused opcodes none. Output channel (out_valid/out_ready, frame, last)
// moves one frame per handshake; last marks the final frame of each item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// write it only while no item is in flight.
// The item register takes an item at its handshake edge; the item's first
// frame then moves from the item register into the output register.
// Throughput: one frame per cycle while the receiver does not stall; an item
// has as many frames as listed above (1 to 12). An item with no frames is
// dropped when taken and never reaches the output register.
// A new item is taken in the same cycle the previous item's last frame moves
// into the output register. When the receiver stalls, the output register
// holds and the item register waits. Synchronous reset empties both stages
// and restores fg 0xFFF, bg 0x000, no invert, width 6.
`include "glyph_row_pixel_frame_encoder_top_macros.svh"

module glyph_row_pixel_frame_encoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [grpfe_pkg::OpcodeW-1:0]      opcode,
  input  logic [7:0]                         value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [grpfe_pkg::FrameW-1:0]       frame,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [grpfe_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [grpfe_pkg::CfgDataW-1:0]     cfg_data
);

  import grpfe_pkg::*;

  // configuration
  logic [ColorW-1:0] fg_color;
  logic [ColorW-1:0] bg_color;
  logic              invert_glyph;
  logic [3:0]        glyph_width;

  // item stage
  item_t      item;
  item_t      item_next;
  logic       item_valid;
  logic [1:0] pair_idx;
  logic [1:0] phase;

  logic       in_fire;
  logic       advance;
  logic       item_last;
  logic       has_frames;
  logic [2:0] width_pairs;

  // frame build
  logic [7:0] glyph_bits;
  logic [1:0] sel;
  logic [3:0] fr, fgn, fb, br, bgn, bb;
  logic [3:0] r1, g1, b1, r2, g2, b2;
  logic [7:0] pair_byte;
  logic [FrameW-1:0] frame_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color     <= 12'hFFF;
      bg_color     <= 12'h000;
      invert_glyph <= 1'b0;
      glyph_width  <= 4'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FG_COLOR:     fg_color     <= cfg_data;
        REG_BG_COLOR:     bg_color     <= cfg_data;
        REG_INVERT_GLYPH: invert_glyph <= cfg_data[0];
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // decode an incoming item
  always_comb begin
    width_pairs = (glyph_width[3:1] > 3'(MaxPairs)) ? 3'(MaxPairs) : glyph_width[3:1];
    item_next   = '0;
    has_frames  = 1'b1;
    case (opcode)
      OP_GLYPH: begin
        item_next.byte_val = value ^ {8{invert_glyph}};
        item_next.pairs    = width_pairs;
        has_frames         = (width_pairs != 3'd0);
      end
      OP_FILL: begin
        // one bg/bg pair: glyph bits all clear
        item_next.pairs = 3'd1;
      end
      OP_CMD: begin
        item_next.single   = 1'b1;
        item_next.byte_val = value;
        item_next.flag     = 1'b0;
      end
      OP_COORD: begin
        item_next.single   = 1'b1;
        item_next.byte_val = byte_rev(value);
        item_next.flag     = 1'b1;
      end
      OP_DATA: begin
        item_next.single   = 1'b1;
        item_next.byte_val = value;
        item_next.flag     = 1'b1;
      end
      default: begin
        has_frames = 1'b0;
      end
    endcase
  end

  assign advance   = item_valid && (!out_valid || out_ready);
  assign item_last = item.single ||
                     ((pair_idx == 2'(item.pairs - 3'd1)) && (phase == PHASE_LAST));
  assign in_ready  = !item_valid || (advance && item_last);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      pair_idx   <= 2'd0;
      phase      <= 2'd0;
    end else begin
      if (in_fire) begin
        item_valid <= has_frames;
        pair_idx   <= 2'd0;
        phase      <= 2'd0;
      end else if (advance) begin
        if (item_last) begin
          item_valid <= 1'b0;
        end else if (phase == PHASE_LAST) begin
          phase    <= 2'd0;
          pair_idx <= pair_idx + 2'd1;
        end else begin
          phase <= phase + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= item_next;
    end
  end

  // pixel pair pattern for the current pair and phase
  always_comb begin
    glyph_bits = item.byte_val << {pair_idx, 1'b0};
    sel = glyph_bits[7:6];
    fr  = nib_rev(fg_color[11:8]);
    fgn = nib_rev(fg_color[7:4]);
    fb  = nib_rev(fg_color[3:0]);
    br  = nib_rev(bg_color[11:8]);
    bgn = nib_rev(bg_color[7:4]);
    bb  = nib_rev(bg_color[3:0]);
    r1  = sel[1] ? fr  : br;
    g1  = sel[1] ? fgn : bgn;
    b1  = sel[1] ? fb  : bb;
    r2  = sel[0] ? fr  : br;
    g2  = sel[0] ? fgn : bgn;
    b2  = sel[0] ? fb  : bb;
    case (phase)
      2'd0:    pair_byte = {g1, r1};
      2'd1:    pair_byte = {r2, b1};
      default: pair_byte = {b2, g2};
    endcase
    if (item.single) begin
      frame_next = {item.byte_val, item.flag};
    end else begin
      frame_next = {pair_byte, 1'b1};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame <= frame_next;
      last  <= item_last;
    end
  end

  `GRPFE_ASSERT_NOW(a_phase_range, clk, rst, item_valid, phase != 2'd3)
  `GRPFE_ASSERT_NOW(a_pair_range, clk, rst, item_valid && !item.single, 3'(pair_idx) < item.pairs)
  `GRPFE_ASSERT_NEXT(a_item_holds, clk, rst, item_valid && !(advance && item_last), item_valid)
  `GRPFE_ASSERT_NEXT(a_empty_drop, clk, rst, in_fire && !has_frames, !item_valid)
  `GRPFE_ASSERT_NEXT(a_frame_shown, clk, rst, advance, out_valid && (last == $past(item_last)))

endmodule

// File: verif/tb_glyph_row_pixel_frame_encoder_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_row_pixel_frame_encoder_top: drives items and register
// writes over valid/ready, predicts every serial frame and compares in order.
// Depends on grpfe_pkg and the encoder RTL.
module tb_glyph_row_pixel_frame_encoder_top;
  import grpfe_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [OpcodeW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpcodeW-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OpcodeW-1:0] OP_SPARE_HI = 3'd7;
  localparam logic [CfgIndexW-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FrameW-1:0] word;
    logic              last;
  } frame_t;

  typedef struct packed {
    logic [OpcodeW-1:0] op;
    logic [7:0]         val;
    logic               typed;
    logic [3:0]         n;
    logic [FrameW-1:0]  word;
  } directed_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [OpcodeW-1:0]   opcode;
  logic [7:0]           value;
  logic                 out_valid;
  logic                 out_ready;
  logic [FrameW-1:0]    frame;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  // register shadows used by the frame predictor
  logic [ColorW-1:0] fg_shadow;
  logic [ColorW-1:0] bg_shadow;
  logic              invert_shadow;
  logic [3:0]        width_shadow;

  frame_t        frames_due[$];
  directed_row_t directed_rows[$];
  frame_t        head;

  int  mismatches;
  int  frames_checked;
  int  items_sent;
  int  glyph_rows;
  int  settings_used;
  int  cycle_count;
  int  hold_left;
  bit  hold_req;
  bit  hold_served;
  bit  tx_idle_on;
  bit  rx_idle_on;

  glyph_row_pixel_frame_encoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .frame     (frame),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [3:0] flip4(input logic [3:0] n);
    logic [3:0] r;
    int i;
    for (i = 0; i < 4; i++) r[i] = n[3-i];
    return r;
  endfunction

  // Expected frames of one item, pushed in order with last on the final one.
  function automatic void expand_item(input logic [OpcodeW-1:0] op, input logic [7:0] val);
    logic [7:0]        bytes [0:11];
    logic              flags [0:11];
    logic [7:0]        bits;
    logic [ColorW-1:0] c1;
    logic [ColorW-1:0] c2;
    int                n;
    int                pairs;
    int                i;
    n = 0;
    if (op == OP_GLYPH || op == OP_FILL) begin
      if (op == OP_GLYPH) begin
        pairs = width_shadow >> 1;
        if (pairs > MaxPairs) pairs = MaxPairs;
        bits = invert_shadow ? ~val : val;
      end else begin
        pairs = 1;
        bits = 8'h00;
      end
      for (i = 0; i < pairs; i++) begin
        c1 = bits[7] ? fg_shadow : bg_shadow;
        c2 = bits[6] ? fg_shadow : bg_shadow;
        bytes[n]   = {flip4(c1[7:4]), flip4(c1[11:8])};
        bytes[n+1] = {flip4(c2[11:8]), flip4(c1[3:0])};
        bytes[n+2] = {flip4(c2[3:0]), flip4(c2[7:4])};
        flags[n] = 1'b1;
        flags[n+1] = 1'b1;
        flags[n+2] = 1'b1;
        n += 3;
        bits = bits << 2;
      end
    end else if (op == OP_CMD) begin
      bytes[0] = val;
      flags[0] = 1'b0;
      n = 1;
    end else if (op == OP_COORD) begin
      bytes[0] = {flip4(val[3:0]), flip4(val[7:4])};
      flags[0] = 1'b1;
      n = 1;
    end else if (op == OP_DATA) begin
      bytes[0] = val;
      flags[0] = 1'b1;
      n = 1;
    end
    for (i = 0; i < n; i++) frames_due.push_back({bytes[i], flags[i], (i == n - 1)});
  endfunction

  function automatic void add_row(input logic [OpcodeW-1:0] op, input logic [7:0] val,
                                  input logic typed, input logic [3:0] n,
                                  input logic [FrameW-1:0] word);
    directed_rows.push_back({op, val, typed, n, word});
  endfunction

  task automatic send_item(input logic [OpcodeW-1:0] op, input logic [7:0] val,
                           input logic typed, input logic [3:0] n,
                           input logic [FrameW-1:0] word);
    int i;
    in_valid <= 1'b1;
    opcode <= op;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      for (i = 0; i < n; i++) frames_due.push_back({word, (i == n - 1)});
    end else begin
      expand_item(op, val);
    end
    items_sent++;
    if (op == OP_GLYPH) glyph_rows++;
    if (tx_idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FG_COLOR:     fg_shadow = data[ColorW-1:0];
      REG_BG_COLOR:     bg_shadow = data[ColorW-1:0];
      REG_INVERT_GLYPH: invert_shadow = data[0];
      REG_GLYPH_WIDTH:  width_shadow = data[3:0];
      default: ;
    endcase
  endtask

  // Stop offering, wait out every expected frame, then let dropped items clear.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int               done;
    int               pick;
    logic [OpcodeW-1:0] op;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 45) op = OP_GLYPH;
      else if (pick < 55) op = OP_FILL;
      else if (pick < 67) op = OP_CMD;
      else if (pick < 79) op = OP_COORD;
      else if (pick < 91) op = OP_DATA;
      else op = OpcodeW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_item(op, 8'($urandom), 1'b0, 4'd0, '0);
      if (op <= OP_DATA) done++;
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, counted here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      hold_served <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_idle_on) begin
      out_ready <= ($urandom_range(99) >= 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        $display("%0t: frame with none expected: actual frame %h last %b", $time, frame, last);
        mismatches++;
      end else begin
        head = frames_due.pop_front();
        frames_checked++;
        if (frame !== head.word) begin
          $display("%0t: frame mismatch: expected %h actual %h", $time, head.word, frame);
          mismatches++;
        end
        if (last !== head.last) begin
          $display("%0t: last mismatch: expected %b actual %b", $time, head.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d frames still due", cycle_count, frames_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int                ph;
    int                r;
    logic [CfgDataW-1:0] fgv;
    logic [CfgDataW-1:0] bgv;
    logic [CfgDataW-1:0] invv;
    logic [CfgDataW-1:0] widv;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_GLYPH;
    value = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FG_COLOR;
    cfg_data = '0;
    hold_req = 1'b0;
    hold_served = 1'b0;
    hold_left = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    mismatches = 0;
    frames_checked = 0;
    items_sent = 0;
    glyph_rows = 0;
    settings_used = 1;
    cycle_count = 0;
    fg_shadow = 12'hFFF;
    bg_shadow = 12'h000;
    invert_shadow = 1'b0;
    width_shadow = 4'd6;

    // Reset defaults: white on black, no invert, three pairs per glyph row.
    add_row(OP_CMD,       8'h00, 1'b1, 4'd1, 9'h000);
    add_row(OP_CMD,       8'hFF, 1'b1, 4'd1, 9'h1FE);
    add_row(OP_CMD,       8'hA5, 1'b1, 4'd1, 9'h14A);
    add_row(OP_DATA,      8'h00, 1'b1, 4'd1, 9'h001);
    add_row(OP_DATA,      8'hFF, 1'b1, 4'd1, 9'h1FF);
    add_row(OP_COORD,     8'h01, 1'b1, 4'd1, 9'h101);
    add_row(OP_COORD,     8'hFF, 1'b1, 4'd1, 9'h1FF);
    add_row(OP_FILL,      8'h00, 1'b1, 4'd3, 9'h001);
    add_row(OP_FILL,      8'hFF, 1'b1, 4'd3, 9'h001);
    add_row(OP_GLYPH,     8'h00, 1'b1, 4'd9, 9'h001);
    add_row(OP_GLYPH,     8'hFF, 1'b1, 4'd9, 9'h1FF);
    add_row(OP_SPARE_LO,  8'hFF, 1'b1, 4'd0, 9'h000);
    add_row(OP_SPARE_MID, 8'h00, 1'b1, 4'd0, 9'h000);
    add_row(OP_SPARE_HI,  8'h5A, 1'b1, 4'd0, 9'h000);
    add_row(OP_GLYPH,     8'hA5, 1'b0, 4'd0, 9'h000);
    add_row(OP_GLYPH,     8'h6C, 1'b0, 4'd0, 9'h000);
    add_row(OP_GLYPH,     8'h81, 1'b0, 4'd0, 9'h000);
    add_row(OP_COORD,     8'h3C, 1'b0, 4'd0, 9'h000);
    add_row(OP_COORD,     8'hA0, 1'b0, 4'd0, 9'h000);
    add_row(OP_DATA,      8'h5A, 1'b0, 4'd0, 9'h000);
    add_row(OP_CMD,       8'h2C, 1'b0, 4'd0, 9'h000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < directed_rows.size(); r++) begin
      send_item(directed_rows[r].op, directed_rows[r].val, directed_rows[r].typed,
                directed_rows[r].n, directed_rows[r].word);
    end

    for (ph = 0; ph < 9; ph++) begin
      drain_outputs();
      case (ph)
        0: begin fgv = 12'h000; bgv = 12'hFFF; invv = 12'h001; widv = 12'h008; end
        1: begin fgv = 12'hA5C; bgv = 12'h3E1; invv = 12'h000; widv = 12'h007; end
        2: begin fgv = 12'h123; bgv = 12'h456; invv = 12'h001; widv = 12'h001; end
        3: begin fgv = 12'hFFF; bgv = 12'h000; invv = 12'h000; widv = 12'h00F; end
        4: begin fgv = 12'h000; bgv = 12'h000; invv = 12'h000; widv = 12'h000; end
        default: begin
          // upper bits of the narrow registers carry junk that must be dropped
          fgv = CfgDataW'($urandom);
          bgv = CfgDataW'($urandom);
          invv = CfgDataW'(($urandom & 32'hFFE) | $urandom_range(0, 1));
          widv = CfgDataW'(($urandom & 32'hFF0) | $urandom_range(0, 15));
        end
      endcase
      write_reg(REG_FG_COLOR, fgv);
      write_reg(REG_BG_COLOR, bgv);
      write_reg(REG_INVERT_GLYPH, invv);
      write_reg(REG_GLYPH_WIDTH, widv);
      if (ph == 3 || ph >= 5) begin
        write_reg(CfgIndexW'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CfgDataW'($urandom));
      end
      cfg_valid <= 1'b0;
      settings_used++;
      tx_idle_on <= (ph != 1);
      rx_idle_on <= (ph != 1);
      if (ph == 0) hold_req <= 1'b1;
      case (ph)
        0, 1, 3: random_items(25);
        2: random_items(20);
        4: random_items(15);
        6: begin
          random_items(12);
          drain_outputs();
          random_items(13);
        end
        default: random_items(20);
      endcase
    end

    drain_outputs();
    repeat (20) @(posedge clk);
    $display("Covered %0d items (%0d glyph rows) across %0d register settings,", items_sent,
             glyph_rows, settings_used);
    $display("with %0d frames compared and %0d mismatches.", frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
